// ===== hw/rtl/rtc3w_pkg.sv =====
// Shared types, constants and BCD helpers for the three-wire RTC serial master.
package rtc3w_pkg;

   localparam int unsigned DIVIDER_WIDTH_DEF = 16;
   localparam int unsigned HALF_REG_WIDTH    = 16;
   localparam logic [15:0] HALF_RESET        = 16'd1;

   localparam logic [6:0] VALUE_MAX  = 7'd99;
   localparam logic [3:0] NIBBLE_MASK = 4'hf;
   localparam logic [7:0] LAST_BIT   = 8'd7;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_CMD  = 2'd1,
      PH_DATA = 2'd2,
      PH_RX   = 2'd3
   } phase_type;

   // Sequencer state, apart from the divider count.
   typedef struct packed {
      phase_type  phase;
      logic [2:0] bit_index;
      logic       clock_half;
      logic       read_mode;
      logic [7:0] command_byte;
      logic [7:0] payload_byte;
      logic [7:0] receive_byte;
   } seq_state_type;

   // One result word.
   typedef struct packed {
      logic [7:0] read_value;
      logic       done_res;
      logic       busy_res;
      logic       io_drive;
      logic       io_out;
      logic       serial_clock;
      logic       chip_enable;
   } result_type;

   // Decimal to packed BCD, saturating at 99. Tens digit by reciprocal (205/2048).
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [6:0]  sat;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      sat      = (v > VALUE_MAX) ? VALUE_MAX : v;
      prod     = 15'(sat) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = {tens, 3'b000} - 7'({tens, 1'b0}) + 7'({tens, 1'b0}) + 7'({tens, 1'b0});
      ones     = sat - tens_x10;
      return {tens, ones[3:0]};
   endfunction

   // Packed BCD to decimal, arithmetic on any nibble value (at most 165).
   function automatic logic [7:0] from_bcd(input logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = b[7:4] & NIBBLE_MASK;
      lo = b[3:0] & NIBBLE_MASK;
      return {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
   endfunction

endpackage

// ===== hw/rtl/three_wire_rtc_serial_master.sv =====
// Top level of the three-wire RTC serial master: ports, state and result registers.
//
// Three-wire RTC serial master. Every req word is one tick of the serial
// sequencer: it carries the start request, the transaction kind (tuser:
// 0 write, 1 read), the register address, the decimal value to write and
// the sampled data pin. Every accepted word yields exactly one rsp word with
// the pin levels after that tick (chip enable, serial clock, data out, data
// drive), busy, a one-tick done flag and, on the done tick of a read, the
// byte read back converted from BCD to decimal. Bits go out and come in LSB
// first; each clock half lasts csr_wdata ticks (0 acts as 1; reset value 1).
// Rate: one word per clock cycle. The tick logic is a single pass between the
// state registers and the rsp output register, so the only limit is the output
// register itself: req_tready is low only while a result waits and rsp_tready
// is low. Write csr only while idle.
module three_wire_rtc_serial_master #(
   parameter int unsigned DIVIDER_WIDTH = rtc3w_pkg::DIVIDER_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] start_req, [8:1] address, [15:9] value, [16] io_in, [23:17] zero
   input  logic [23:0] req_tdata,
   // [0] mode
   input  logic        req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] chip_enable, [1] serial_clock, [2] io_out, [3] io_drive,
   // [4] busy_res, [5] done_res, [13:6] read_value, [15:14] zero
   output logic [15:0] rsp_tdata,
   // half-period register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   rtc3w_pkg::seq_state_type  state_ff, state_in;
   logic [DIVIDER_WIDTH-1:0]  tick_ff, tick_in;
   logic [15:0]               half_ff;
   logic [31:0]               half_ext;
   logic [DIVIDER_WIDTH-1:0]  half_period;
   logic                      rsp_valid_ff;
   rtc3w_pkg::result_type     rsp_data_ff, result;
   logic                      req_accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // register is 16 bits; the divider sees its low DIVIDER_WIDTH bits
   assign half_ext    = {16'd0, half_ff};
   assign half_period = half_ext[DIVIDER_WIDTH-1:0];

   rtc3w_step #(
      .DIVIDER_WIDTH (DIVIDER_WIDTH)
   ) u_step (
      .cur_state   (state_ff),
      .cur_tick    (tick_ff),
      .half_period (half_period),
      .start_req   (req_tdata[0]),
      .mode        (req_tuser),
      .address     (req_tdata[8:1]),
      .value       (req_tdata[15:9]),
      .io_in       (req_tdata[16]),
      .nxt_state   (state_in),
      .nxt_tick    (tick_in),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= rtc3w_pkg::HALF_RESET;
      end else if (csr_valid && csr_ready) begin
         half_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         tick_ff  <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
      end
   end

   // output register; frees up as soon as the word is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   // divider count is parked at zero whenever idle
   a_idle_tick_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == rtc3w_pkg::PH_IDLE |-> tick_ff == '0)
      else $error("tick count nonzero while idle");

   // sequencer only moves on an accepted word
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff) && $stable(tick_ff))
      else $error("state changed without an accepted word");

   // done tick reports enable already low
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> !rsp_data_ff.busy_res &&
      !rsp_data_ff.chip_enable && !rsp_data_ff.io_drive)
      else $error("done with transaction still active");

   // read data only shows on a done tick
   a_value_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.read_value != 8'd0 |-> rsp_data_ff.done_res)
      else $error("read value outside done tick");

   // pins quiet unless busy
   a_pins_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.busy_res |->
      !rsp_data_ff.serial_clock && !rsp_data_ff.io_out)
      else $error("pin activity while idle");

endmodule

// ===== hw/rtl/rtc3w_step.sv =====
// Next-state and output logic for one tick of the three-wire sequencer.
module rtc3w_step #(
   parameter int unsigned DIVIDER_WIDTH = rtc3w_pkg::DIVIDER_WIDTH_DEF
) (
   input  rtc3w_pkg::seq_state_type   cur_state,
   input  logic [DIVIDER_WIDTH-1:0]   cur_tick,
   input  logic [DIVIDER_WIDTH-1:0]   half_period,
   input  logic                       start_req,
   input  logic                       mode,
   input  logic [7:0]                 address,
   input  logic [6:0]                 value,
   input  logic                       io_in,
   output rtc3w_pkg::seq_state_type   nxt_state,
   output logic [DIVIDER_WIDTH-1:0]   nxt_tick,
   output rtc3w_pkg::result_type      result
);

   logic [DIVIDER_WIDTH-1:0] half_eff;
   logic [DIVIDER_WIDTH:0]   tick_inc;
   logic                     half_end;
   logic [7:0]               rx_upd;
   logic                     done;
   logic [7:0]               rv;
   logic                     busy;
   logic                     drive;
   logic [7:0]               src;

   assign half_eff = (half_period == '0) ? DIVIDER_WIDTH'(1) : half_period;
   assign tick_inc = {1'b0, cur_tick} + (DIVIDER_WIDTH+1)'(1);
   assign half_end = (tick_inc >= {1'b0, half_eff});
   assign rx_upd   = cur_state.receive_byte | (8'(io_in) << cur_state.bit_index);

   always_comb begin
      nxt_state = cur_state;
      nxt_tick  = cur_tick;
      done      = 1'b0;
      rv        = '0;
      if (cur_state.phase == rtc3w_pkg::PH_IDLE) begin
         if (start_req) begin
            nxt_state.read_mode    = mode;
            nxt_state.command_byte = mode ? (address + 8'd1) : address;
            nxt_state.payload_byte = rtc3w_pkg::to_bcd(value);
            nxt_state.receive_byte = '0;
            nxt_state.bit_index    = '0;
            nxt_state.clock_half   = 1'b0;
            nxt_state.phase        = rtc3w_pkg::PH_CMD;
            nxt_tick               = '0;
         end
      end else if (!half_end) begin
         nxt_tick = tick_inc[DIVIDER_WIDTH-1:0];
      end else begin
         nxt_tick = '0;
         unique case (cur_state.phase)
            rtc3w_pkg::PH_CMD, rtc3w_pkg::PH_DATA: begin
               if (!cur_state.clock_half) begin
                  nxt_state.clock_half = 1'b1;
               end else begin
                  nxt_state.clock_half = 1'b0;
                  if (8'(cur_state.bit_index) < rtc3w_pkg::LAST_BIT) begin
                     nxt_state.bit_index = cur_state.bit_index + 3'd1;
                  end else begin
                     nxt_state.bit_index = '0;
                     if (cur_state.phase == rtc3w_pkg::PH_CMD) begin
                        nxt_state.phase = cur_state.read_mode ? rtc3w_pkg::PH_RX
                                                              : rtc3w_pkg::PH_DATA;
                     end else begin
                        nxt_state.phase = rtc3w_pkg::PH_IDLE;
                        done            = 1'b1;
                     end
                  end
               end
            end
            rtc3w_pkg::PH_RX: begin
               if (!cur_state.clock_half) begin
                  // sample at the last tick of the low half
                  nxt_state.receive_byte = rx_upd;
                  if (8'(cur_state.bit_index) >= rtc3w_pkg::LAST_BIT) begin
                     nxt_state.phase     = rtc3w_pkg::PH_IDLE;
                     nxt_state.bit_index = '0;
                     done                = 1'b1;
                     rv                  = rtc3w_pkg::from_bcd(rx_upd);
                  end else begin
                     nxt_state.clock_half = 1'b1;
                  end
               end else begin
                  nxt_state.clock_half = 1'b0;
                  nxt_state.bit_index  = cur_state.bit_index + 3'd1;
               end
            end
            default: begin
               nxt_state.phase      = rtc3w_pkg::PH_IDLE;
               nxt_state.bit_index  = '0;
               nxt_state.clock_half = 1'b0;
            end
         endcase
      end
   end

   assign busy  = (nxt_state.phase != rtc3w_pkg::PH_IDLE);
   assign drive = (nxt_state.phase == rtc3w_pkg::PH_CMD) ||
                  (nxt_state.phase == rtc3w_pkg::PH_DATA);
   assign src   = (nxt_state.phase == rtc3w_pkg::PH_DATA) ? nxt_state.payload_byte
                                                          : nxt_state.command_byte;

   always_comb begin
      result              = '0;
      result.chip_enable  = busy;
      result.serial_clock = busy & nxt_state.clock_half;
      result.io_out       = drive & src[nxt_state.bit_index];
      result.io_drive     = drive;
      result.busy_res     = busy;
      result.done_res     = done;
      result.read_value   = rv;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the three-wire RTC serial master, one tick per req word.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 1_500_000;

   // One tick as offered on the req channel.
   typedef struct {
      logic       start;
      logic       mode;
      logic [7:0] addr;
      logic [6:0] value;
      logic       io;
   } tick_type;

   // Which level the data pin reads back during a directed transaction.
   typedef enum int {PIN_LOW, PIN_HIGH, PIN_RANDOM} pin_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [0] start_req, [8:1] address, [15:9] value, [16] io_in
   logic        req_tuser = 1'b0; // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [0] ce, [1] sclk, [2] io_out, [3] io_drive,
                                  // [4] busy, [5] done, [13:6] read_value
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;

   three_wire_rtc_serial_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Pending ticks (filled by the sequence below) and the pin levels they should produce.
   tick_type              tick_q[$];
   rtc3w_pkg::result_type pin_q[$];
   tick_type              req_cur;

   bit          idle_on = 1'b0;
   int          req_count = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          cycle_count = 0;
   int          mismatch_count = 0;
   int          writes_done = 0;
   int          reads_done = 0;

   // ------------------------------------------------------------------
   // Sequencer mirror: same state the block keeps, advanced once per
   // accepted tick.
   // ------------------------------------------------------------------
   logic [15:0]          half_cfg = 16'd1;
   rtc3w_pkg::phase_type seq_phase = rtc3w_pkg::PH_IDLE;
   logic [3:0]           bit_idx = '0;
   logic                 clk_half = 1'b0;
   logic [15:0]          tick_cnt = '0;
   logic                 is_read = 1'b0;
   logic [7:0]           cmd_byte = '0;
   logic [7:0]           data_byte = '0;
   logic [7:0]           rx_byte = '0;

   function automatic rtc3w_pkg::result_type rtc_tick(input tick_type w);
      rtc3w_pkg::result_type r;
      logic [15:0] span;
      logic [6:0]  sat;
      logic [7:0]  src;
      logic        finished;
      logic        busy;
      logic        drive;
      r        = '0;
      finished = 1'b0;
      // a zero half period behaves like one tick per half
      span = (half_cfg == 16'd0) ? 16'd1 : half_cfg;
      if (seq_phase == rtc3w_pkg::PH_IDLE) begin
         if (w.start) begin
            // reads go out with address plus one, wrapping 255 to 0
            is_read   = w.mode;
            cmd_byte  = w.mode ? w.addr + 8'd1 : w.addr;
            sat       = (w.value > 7'd99) ? 7'd99 : w.value;
            data_byte = {4'(sat / 7'd10), 4'(sat % 7'd10)};
            rx_byte   = '0;
            bit_idx   = '0;
            clk_half  = 1'b0;
            tick_cnt  = '0;
            seq_phase = rtc3w_pkg::PH_CMD;
         end
      end else if (17'(tick_cnt) + 17'd1 < 17'(span)) begin
         tick_cnt = tick_cnt + 16'd1;
      end else begin
         tick_cnt = '0;
         case (seq_phase)
            rtc3w_pkg::PH_CMD, rtc3w_pkg::PH_DATA: begin
               if (!clk_half) begin
                  clk_half = 1'b1;
               end else begin
                  clk_half = 1'b0;
                  if (bit_idx < 4'd7) begin
                     bit_idx = bit_idx + 4'd1;
                  end else begin
                     bit_idx = '0;
                     if (seq_phase == rtc3w_pkg::PH_CMD) begin
                        seq_phase = is_read ? rtc3w_pkg::PH_RX : rtc3w_pkg::PH_DATA;
                     end else begin
                        seq_phase = rtc3w_pkg::PH_IDLE;
                        finished  = 1'b1;
                     end
                  end
               end
            end
            rtc3w_pkg::PH_RX: begin
               // sample at the end of each low half; 8 samples, 7 pulses between
               if (!clk_half) begin
                  rx_byte[bit_idx[2:0]] = w.io;
                  if (bit_idx >= 4'd7) begin
                     seq_phase    = rtc3w_pkg::PH_IDLE;
                     bit_idx      = '0;
                     finished     = 1'b1;
                     r.read_value = 8'(rx_byte[7:4]) * 8'd10 + 8'(rx_byte[3:0]);
                  end else begin
                     clk_half = 1'b1;
                  end
               end else begin
                  clk_half = 1'b0;
                  bit_idx  = bit_idx + 4'd1;
               end
            end
            default: begin
               seq_phase = rtc3w_pkg::PH_IDLE;
            end
         endcase
      end
      if (finished) begin
         if (is_read) reads_done++;
         else writes_done++;
      end
      busy  = (seq_phase != rtc3w_pkg::PH_IDLE);
      drive = (seq_phase == rtc3w_pkg::PH_CMD) || (seq_phase == rtc3w_pkg::PH_DATA);
      src   = (seq_phase == rtc3w_pkg::PH_DATA) ? data_byte : cmd_byte;
      r.chip_enable  = busy;
      r.serial_clock = busy & clk_half;
      r.io_out       = drive & src[bit_idx[2:0]];
      r.io_drive     = drive;
      r.busy_res     = busy;
      r.done_res     = finished;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: pops the next tick whenever the slot is free, with
   // optional idle bursts after a word.
   // ------------------------------------------------------------------
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pin_q.push_back(rtc_tick(req_cur));
            req_count <= req_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (tick_q.size() != 0) begin
               req_cur = tick_q.pop_front();
               req_tdata  <= {7'd0, req_cur.io, req_cur.value, req_cur.addr, req_cur.start};
               req_tuser  <= req_cur.mode;
               req_tvalid <= 1'b1;
               if (idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, once, so the output register fills and req stalls.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && req_count >= 300) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: compares every rsp word against the oldest
   // predicted pin state, field by field.
   // ------------------------------------------------------------------
   int stall_left = 0;

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rtc3w_pkg::result_type want;
      rtc3w_pkg::result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rtc3w_pkg::result_type'(rsp_tdata[13:0]);
            if (pin_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected rsp word, expected none, actual 0x%04h",
                        $time, rsp_tdata);
            end else begin
               want = pin_q.pop_front();
               check_field("chip_enable", want.chip_enable, got.chip_enable);
               check_field("serial_clock", want.serial_clock, got.serial_clock);
               check_field("io_out", want.io_out, got.io_out);
               check_field("io_drive", want.io_drive, got.io_drive);
               check_field("busy", want.busy_res, got.busy_res);
               check_field("done", want.done_res, got.done_res);
               check_field("read_value", want.read_value, got.read_value);
               check_field("pad bits", 0, rsp_tdata[15:14]);
            end
         end
         if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 13);
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (hold_left == 0);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected", cycle_count,
                  pin_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [6:0] rand_value();
      // mostly legal decimals, some above 99 to hit saturation
      return ($urandom_range(0, 4) == 0) ? 7'($urandom_range(100, 127))
                                         : 7'($urandom_range(0, 99));
   endfunction

   // Idle ticks long enough for any transaction at this half period to finish.
   task automatic push_quiet(input int n);
      tick_type t;
      for (int i = 0; i < n; i++) begin
         t.start = 1'b0;
         t.mode  = 1'($urandom_range(0, 1));
         t.addr  = 8'($urandom_range(0, 255));
         t.value = rand_value();
         t.io    = 1'($urandom_range(0, 1));
         tick_q.push_back(t);
      end
   endtask

   // One transaction request followed by its full run of ticks.
   task automatic push_txn(input logic mode, input logic [7:0] addr, input logic [6:0] value,
                           input pin_kind_type pin, input logic keep_start);
      tick_type t;
      t.start = 1'b1;
      t.mode  = mode;
      t.addr  = addr;
      t.value = value;
      t.io    = 1'b0;
      tick_q.push_back(t);
      for (int i = 0; i < 34; i++) begin
         t.start = keep_start;
         t.io    = (pin == PIN_RANDOM) ? 1'($urandom_range(0, 1)) : (pin == PIN_HIGH);
         tick_q.push_back(t);
      end
   endtask

   // Random ticks; a start about every fourth idle tick, starts while busy are noise.
   task automatic push_random(input int n);
      tick_type t;
      for (int i = 0; i < n; i++) begin
         t.start = ($urandom_range(0, 3) == 0);
         t.mode  = 1'($urandom_range(0, 1));
         t.addr  = 8'($urandom_range(0, 255));
         t.value = rand_value();
         t.io    = 1'($urandom_range(0, 1));
         tick_q.push_back(t);
      end
   endtask

   // Sampled at the falling edge, away from the edge where the blocks update.
   task automatic wait_drained();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_tvalid || pin_q.size() != 0);
   endtask

   task automatic write_half(input logic [15:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock);
      while (!csr_ready);
      half_cfg = v;
      csr_valid <= 1'b0;
   endtask

   // Random phase at one half period, closed by enough quiet ticks to go idle.
   task automatic run_phase(input logic [15:0] half, input int n, input bit with_idle);
      int span;
      span = (half == 16'd0) ? 1 : int'(half);
      write_half(half);
      idle_on = with_idle;
      push_random(n);
      push_quiet(33 * span + 2);
      wait_drained();
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      tick_type t;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed transactions at the reset half period of one tick
      idle_on = 1'b1;
      push_txn(1'b0, 8'h80, 7'd0, PIN_LOW, 1'b0);
      push_txn(1'b0, 8'hff, 7'd99, PIN_LOW, 1'b0);
      push_txn(1'b0, 8'h00, 7'd127, PIN_LOW, 1'b0);   // saturates to 99
      push_txn(1'b0, 8'h55, 7'd100, PIN_LOW, 1'b0);
      push_txn(1'b1, 8'hff, 7'd0, PIN_HIGH, 1'b0);    // address wraps, reads 0xff -> 165
      push_txn(1'b1, 8'h81, 7'd42, PIN_LOW, 1'b0);
      push_txn(1'b1, 8'h7e, 7'd31, PIN_RANDOM, 1'b0);
      // start held high: ignored while busy and on the done tick
      push_txn(1'b0, 8'h3c, 7'd58, PIN_RANDOM, 1'b1);
      push_txn(1'b1, 8'ha5, 7'd7, PIN_HIGH, 1'b1);
      push_quiet(35);
      wait_drained();

      // random phases across half periods, zero acting as one
      run_phase(16'd0, 100, 1'b1);
      run_phase(16'd2, 100, 1'b0);
      run_phase(16'd3, 80, 1'b1);
      run_phase(16'd1, 100, 1'b1);
      run_phase(16'd5, 60, 1'b1);

      // widest divider, no idling: one write starts and sits in its first clock half
      write_half(16'hffff);
      idle_on = 1'b0;
      t.start = 1'b1;
      t.mode  = 1'b0;
      t.addr  = 8'($urandom_range(0, 255));
      t.value = rand_value();
      t.io    = 1'b0;
      tick_q.push_back(t);
      push_random(60);
      wait_drained();

      // the rsp output is registered; give any stray word time to show up
      repeat (4) @(posedge clock);
      $display("Covered %0d writes and %0d reads over %0d ticks, half periods 0 to 65535.",
               writes_done, reads_done, req_count);
      $display("Field mismatches: %0d, words still expected: %0d", mismatch_count,
               pin_q.size());
      if (mismatch_count == 0 && pin_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
